### rtl/tkm_pkg.sv
package tkm_pkg;

   // Defaults for the top-level parameters.
   localparam int STREAMS_DEF      = 8;
   localparam int STREAM_DEPTH_DEF = 256;
   localparam int ROW_BITS_DEF     = 32;
   localparam int MAX_CHUNK_DEF    = 16;

   // Fixed field widths of the two channels.
   localparam int REQ_STREAM_W = 3;
   localparam int REQ_ROW_W    = 32;
   localparam int TAG_W        = 8;
   localparam int CHUNK_W      = 5;
   localparam int RSP_ROW_W    = 32;

   // Operation codes on req_op.
   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_PULL   = 1'b1;

   // Status codes on rsp_status.
   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_DROPPED = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } tkm_state_type;

endpackage

### rtl/tkm_store.sv
module tkm_store import tkm_pkg::*; #(
   parameter int ENTRIES  = STREAMS_DEF * STREAM_DEPTH_DEF,
   parameter int ROW_BITS = ROW_BITS_DEF,
   localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       addr,
   input  logic [ROW_BITS-1:0] wr_data,
   output logic [ROW_BITS-1:0] rd_data
);

   // Single-port row store; contents are undefined until written.
   logic [ROW_BITS-1:0] mem [ENTRIES];
   logic [ROW_BITS-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_ff <= mem[addr];
   end

   assign rd_data = rd_ff;

endmodule

### rtl/tagged_kway_merge.sv
// Tagged k-way merge of sorted row-id streams. The block keeps STREAMS
// first-in first-out queues of row ids, each STREAM_DEPTH entries deep and
// each carrying an 8-bit tag, with all rows in one single-port row store. An
// append beat (req_op = 0) pushes req_row_value onto queue req_stream, sets
// that queue's tag and returns one beat with has_item low and last high;
// status is high when the queue was full or the index is out of range, and
// then nothing changes. A pull beat (req_op = 1) returns up to req_chunk_len
// beats (zero counts as one, and the count saturates at MAX_CHUNK), each the
// smallest head row among the non-empty queues with that queue's tag; equal
// rows go to the lowest queue index. The run ends early, with last set on
// the final row, once every queue is empty, and a pull that finds all queues
// empty returns a single beat with has_item low and last high. For each
// merged row of a pull, one shared comparator walks the queue heads one per
// cycle through the store's single read port (STREAMS reads from a store
// with a registered read), and then, once the output is free, the result is
// loaded and the head retired. The input side is stalled while a pull is
// running or while a finished result beat is still waiting to be taken.
module tagged_kway_merge import tkm_pkg::*; #(
   parameter int STREAMS      = STREAMS_DEF,
   parameter int STREAM_DEPTH = STREAM_DEPTH_DEF,
   parameter int ROW_BITS     = ROW_BITS_DEF,
   parameter int MAX_CHUNK    = MAX_CHUNK_DEF
) (
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_op,
   input  logic [REQ_STREAM_W-1:0] req_stream,
   input  logic [REQ_ROW_W-1:0]    req_row_value,
   input  logic [TAG_W-1:0]        req_stream_tag,
   input  logic [CHUNK_W-1:0]      req_chunk_len,

   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [RSP_ROW_W-1:0]    rsp_out_row,
   output logic [TAG_W-1:0]        rsp_out_tag,
   output logic                    rsp_has_item,
   output logic                    rsp_last,
   output logic                    rsp_status
);

   localparam int ENTRIES = STREAMS * STREAM_DEPTH;
   localparam int SW      = $clog2(STREAMS);
   localparam int CW      = $clog2(STREAMS + 1);
   localparam int HW      = $clog2(STREAM_DEPTH);
   localparam int FW      = $clog2(STREAM_DEPTH + 1);
   localparam int AW      = $clog2(ENTRIES);
   localparam int TW      = $clog2(ENTRIES + 1);
   localparam int KW      = $clog2(MAX_CHUNK + 1);

   tkm_state_type state_ff, state_in;

   // Per-queue bookkeeping.
   logic [HW-1:0]    head_ff [STREAMS];
   logic [FW-1:0]    fill_ff [STREAMS];
   logic [TAG_W-1:0] tag_ff  [STREAMS];
   logic [TW-1:0]    total_ff, total_in;

   // Pull sequencer.
   logic [CW-1:0]       scan_ff, scan_in;
   logic [KW-1:0]       want_ff, want_in;
   logic [KW-1:0]       cnt_ff, cnt_in;
   // Stage that lines up a queue's index and tag with its head row coming
   // back from the store's registered read.
   logic                p_valid_ff, p_valid_in;
   logic [SW-1:0]       p_idx_ff, p_idx_in;
   logic [TAG_W-1:0]    p_tag_ff, p_tag_in;
   // Running minimum of the current scan.
   logic                best_valid_ff, best_valid_in;
   logic [SW-1:0]       best_idx_ff, best_idx_in;
   logic [TAG_W-1:0]    best_tag_ff, best_tag_in;
   logic [ROW_BITS-1:0] best_row_ff, best_row_in;

   // Result register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_ROW_W-1:0] rsp_row_ff, rsp_row_in;
   logic [TAG_W-1:0]     rsp_tag_ff, rsp_tag_in;
   logic                 rsp_has_ff, rsp_has_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_status_ff, rsp_status_in;

   // Store port and queue updates.
   logic                mem_we;
   logic [AW-1:0]       mem_addr;
   logic [ROW_BITS-1:0] mem_rdata;
   logic [SW-1:0]       rd_idx;
   logic [SW-1:0]       req_idx;
   logic [HW-1:0]       head_rd;
   logic [FW-1:0]       fill_rd;
   logic [HW:0]         pos_sum;
   logic [HW-1:0]       pos;
   logic [HW-1:0]       head_next;
   logic                out_free;
   logic                accept;
   logic                req_in_range;
   logic                append_ok;
   logic                push_en;
   logic                pop_en;

   assign req_idx      = SW'(req_stream);
   assign req_in_range = int'(req_stream) < STREAMS;
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign req_stall    = !((state_ff == ST_IDLE) && out_free);
   assign accept       = req_valid && !req_stall;

   // One bookkeeping read address per cycle, chosen by the sequencer state.
   always_comb begin
      unique case (state_ff)
         ST_SCAN: rd_idx = scan_ff[SW-1:0];
         ST_EMIT: rd_idx = best_idx_ff;
         default: rd_idx = req_idx;
      endcase
   end

   assign head_rd   = head_ff[rd_idx];
   assign fill_rd   = fill_ff[rd_idx];
   assign pos_sum   = (HW+1)'(head_rd) + (HW+1)'(fill_rd);
   assign head_next = (int'(head_rd) == STREAM_DEPTH - 1) ? '0 : head_rd + 1'b1;
   assign append_ok = req_in_range && (int'(fill_rd) < STREAM_DEPTH);

   // Tail slot for an append, head slot for a scan read.
   always_comb begin
      if (state_ff == ST_IDLE) begin
         if (int'(pos_sum) >= STREAM_DEPTH) begin
            pos = HW'(pos_sum - (HW+1)'(STREAM_DEPTH));
         end else begin
            pos = HW'(pos_sum);
         end
      end else begin
         pos = head_rd;
      end
   end

   assign mem_addr = AW'(rd_idx) * AW'(STREAM_DEPTH) + AW'(pos);

   tkm_store #(
      .ENTRIES  (ENTRIES),
      .ROW_BITS (ROW_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .addr    (mem_addr),
      .wr_data (ROW_BITS'(req_row_value)),
      .rd_data (mem_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      total_in      = total_ff;
      scan_in       = scan_ff;
      want_in       = want_ff;
      cnt_in        = cnt_ff;
      p_valid_in    = 1'b0;
      p_idx_in      = p_idx_ff;
      p_tag_in      = p_tag_ff;
      best_valid_in = best_valid_ff;
      best_idx_in   = best_idx_ff;
      best_tag_in   = best_tag_ff;
      best_row_in   = best_row_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_row_in    = rsp_row_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_has_in    = rsp_has_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      push_en       = 1'b0;
      pop_en        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_op == OP_APPEND) begin
                  mem_we        = append_ok;
                  push_en       = append_ok;
                  total_in      = append_ok ? total_ff + 1'b1 : total_ff;
                  rsp_valid_in  = 1'b1;
                  rsp_row_in    = '0;
                  rsp_tag_in    = '0;
                  rsp_has_in    = 1'b0;
                  rsp_last_in   = 1'b1;
                  rsp_status_in = append_ok ? STATUS_OK : STATUS_DROPPED;
               end else if (total_ff == '0) begin
                  // Nothing queued anywhere: a single empty final beat.
                  rsp_valid_in  = 1'b1;
                  rsp_row_in    = '0;
                  rsp_tag_in    = '0;
                  rsp_has_in    = 1'b0;
                  rsp_last_in   = 1'b1;
                  rsp_status_in = STATUS_OK;
               end else begin
                  if (req_chunk_len == '0) begin
                     want_in = KW'(1);
                  end else if (int'(req_chunk_len) > MAX_CHUNK) begin
                     want_in = KW'(MAX_CHUNK);
                  end else begin
                     want_in = KW'(req_chunk_len);
                  end
                  cnt_in        = '0;
                  scan_in       = '0;
                  best_valid_in = 1'b0;
                  state_in      = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            // Issue the head read of one queue while comparing the row that
            // the previous cycle's read returned.
            if (int'(scan_ff) < STREAMS) begin
               p_valid_in = (fill_rd != '0);
               p_idx_in   = scan_ff[SW-1:0];
               p_tag_in   = tag_ff[scan_ff[SW-1:0]];
               scan_in    = scan_ff + 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
            // Strict less-than keeps the lowest index on equal rows.
            if (p_valid_ff && (!best_valid_ff || (mem_rdata < best_row_ff))) begin
               best_valid_in = 1'b1;
               best_idx_in   = p_idx_ff;
               best_tag_in   = p_tag_ff;
               best_row_in   = mem_rdata;
            end
         end

         ST_EMIT: begin
            // total_ff is nonzero at every scan, so the minimum is valid.
            if (out_free) begin
               pop_en        = 1'b1;
               total_in      = total_ff - 1'b1;
               cnt_in        = cnt_ff + 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_row_in    = RSP_ROW_W'(best_row_ff);
               rsp_tag_in    = best_tag_ff;
               rsp_has_in    = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_last_in   = (cnt_ff + 1'b1 == want_ff) || (total_ff == TW'(1));
               scan_in       = '0;
               best_valid_in = 1'b0;
               state_in      = rsp_last_in ? ST_IDLE : ST_SCAN;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         total_ff      <= '0;
         p_valid_ff    <= 1'b0;
         best_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         scan_ff       <= '0;
         cnt_ff        <= '0;
         want_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         total_ff      <= total_in;
         p_valid_ff    <= p_valid_in;
         best_valid_ff <= best_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         scan_ff       <= scan_in;
         cnt_ff        <= cnt_in;
         want_ff       <= want_in;
      end
   end

   always_ff @(posedge clock) begin
      p_idx_ff      <= p_idx_in;
      p_tag_ff      <= p_tag_in;
      best_idx_ff   <= best_idx_in;
      best_tag_ff   <= best_tag_in;
      best_row_ff   <= best_row_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_has_ff    <= rsp_has_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Queue pointers: an append grows the queue at rd_idx, a retired head
   // advances the winning queue, also at rd_idx.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STREAMS; i++) begin
            head_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
      end else if (push_en) begin
         fill_ff[rd_idx] <= fill_rd + 1'b1;
      end else if (pop_en) begin
         fill_ff[rd_idx] <= fill_rd - 1'b1;
         head_ff[rd_idx] <= head_next;
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         tag_ff[rd_idx] <= req_stream_tag;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_row  = rsp_row_ff;
   assign rsp_out_tag  = rsp_tag_ff;
   assign rsp_has_item = rsp_has_ff;
   assign rsp_last     = rsp_last_ff;
   assign rsp_status   = rsp_status_ff;

endmodule
